// ===== rtl/core/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the coordinate binary search block.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COORD_BITS  = 8;
  localparam int ENTRY_BITS  = 2 * COORD_BITS;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = 5;
  localparam int BOUND_BITS  = 6;

  localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(TABLE_DEPTH);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SEARCH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   addr;
    logic [ENTRY_BITS-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic                found;
    logic [IDX_BITS-1:0] index;
  } res_t;

endpackage

// ===== rtl/core/coordinate_binary_search.sv =====
// ----------------------------------------------------------------------------
// coordinate_binary_search
// Sorted coordinate table with a (y, x) binary search over an index window.
//
//   channel   dir  fields
//   s_axis    in   tuser: action; tdata: entry_index, key_x, key_y,
//                  low_bound, high_bound
//   m_axis    out  tuser: found; tdata: found_index
//   cfg       in   data: entries_in_use
//
// Loads and out-of-range searches go straight to the result; a search makes
// up to 5 probes, each a registered table read and then the shared comparator,
// and a miss ends with a probe step that finds the window empty.
// Reset leaves the table contents undefined and sets entries_in_use to 16.
// An output register holds one waiting result, so the next item is taken
// while it waits on m_axis_tready; a second result stalls s_axis_tready.
// ----------------------------------------------------------------------------
module coordinate_binary_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index[3:0], key_x[11:4], key_y[19:12],
                                     // low_bound[25:20], high_bound[31:26]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // found_index[3:0], zero fill above
  output logic        m_axis_tuser,  // found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  logic [cbs_pkg::CNT_BITS-1:0]   entries_q;
  logic [cbs_pkg::CNT_BITS-1:0]   count;
  cbs_pkg::tbl_wr_t               tbl_wr;
  logic [cbs_pkg::IDX_BITS-1:0]   tbl_raddr;
  logic [cbs_pkg::ENTRY_BITS-1:0] tbl_rdata;
  logic                           res_valid, res_ready;
  cbs_pkg::res_t                  res;
  logic                           out_valid_q;
  cbs_pkg::res_t                  out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= cbs_pkg::COUNT_RESET;
    end else if (cfg_valid_i) begin
      entries_q <= cfg_data_i;
    end
  end

  // Counts above the table depth search the whole table.
  assign count = (entries_q > cbs_pkg::COUNT_RESET) ? cbs_pkg::COUNT_RESET : entries_q;

  cbs_table u_table (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  cbs_search u_search (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_action_i      (cbs_pkg::action_e'(s_axis_tuser)),
    .in_entry_index_i (s_axis_tdata[3:0]),
    .in_key_x_i       (s_axis_tdata[11:4]),
    .in_key_y_i       (s_axis_tdata[19:12]),
    .in_low_i         (s_axis_tdata[25:20]),
    .in_high_i        (s_axis_tdata[31:26]),
    .count_i          (count),
    .tbl_wr_o         (tbl_wr),
    .tbl_raddr_o      (tbl_raddr),
    .tbl_rdata_i      (tbl_rdata),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {{(8 - cbs_pkg::IDX_BITS){1'b0}}, out_q.index};

endmodule

// ===== rtl/core/cbs_table.sv =====
// ----------------------------------------------------------------------------
// cbs_table
// Coordinate table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbs_table (
  input  logic                          clk_i,
  input  cbs_pkg::tbl_wr_t              wr_i,
  input  logic [cbs_pkg::IDX_BITS-1:0]   raddr_i,
  output logic [cbs_pkg::ENTRY_BITS-1:0] rdata_o
);

  logic [cbs_pkg::ENTRY_BITS-1:0] mem [cbs_pkg::TABLE_DEPTH];
  logic [cbs_pkg::ENTRY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cbs_search.sv =====
// ----------------------------------------------------------------------------
// cbs_search
// Sequencer for table loads and the binary search, with the shared key
// comparator that is used once per probe.
// ----------------------------------------------------------------------------
module cbs_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cbs_pkg::action_e                in_action_i,
  input  logic [cbs_pkg::IDX_BITS-1:0]     in_entry_index_i,
  input  logic signed [cbs_pkg::COORD_BITS-1:0] in_key_x_i,
  input  logic signed [cbs_pkg::COORD_BITS-1:0] in_key_y_i,
  input  logic signed [cbs_pkg::BOUND_BITS-1:0] in_low_i,
  input  logic signed [cbs_pkg::BOUND_BITS-1:0] in_high_i,
  input  logic [cbs_pkg::CNT_BITS-1:0]     count_i,
  output cbs_pkg::tbl_wr_t                tbl_wr_o,
  output logic [cbs_pkg::IDX_BITS-1:0]     tbl_raddr_o,
  input  logic [cbs_pkg::ENTRY_BITS-1:0]   tbl_rdata_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output cbs_pkg::res_t                   res_o
);

  localparam logic [cbs_pkg::COORD_BITS-1:0] SIGN_FLIP =
    {1'b1, {(cbs_pkg::COORD_BITS-1){1'b0}}};

  cbs_pkg::state_e state_q, state_d;

  logic signed [cbs_pkg::BOUND_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [cbs_pkg::IDX_BITS-1:0]          mid_q, mid_d;
  logic [cbs_pkg::ENTRY_BITS-1:0]        key_q, key_d;
  cbs_pkg::res_t                         res_q, res_d;

  logic                                  accept;
  logic                                  bounds_ok;
  logic [cbs_pkg::BOUND_BITS-1:0]        sum;
  logic [cbs_pkg::IDX_BITS-1:0]          mid_w;
  logic [cbs_pkg::ENTRY_BITS-1:0]        entry_key;
  logic                                  key_eq, key_gt;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == cbs_pkg::ST_IDLE);

  // A load is written straight into the table at its transfer.
  assign tbl_wr_o.en   = accept && (in_action_i == cbs_pkg::ACT_LOAD);
  assign tbl_wr_o.addr = in_entry_index_i;
  assign tbl_wr_o.data = {in_key_y_i, in_key_x_i};

  assign bounds_ok = !in_low_i[cbs_pkg::BOUND_BITS-1] && !in_high_i[cbs_pkg::BOUND_BITS-1] &&
                     (in_low_i[cbs_pkg::CNT_BITS-1:0] < count_i) &&
                     (in_high_i[cbs_pkg::CNT_BITS-1:0] < count_i);

  // Both bounds are within the table whenever a probe is issued.
  assign sum   = {1'b0, lo_q[cbs_pkg::BOUND_BITS-2:0]} + {1'b0, hi_q[cbs_pkg::BOUND_BITS-2:0]};
  assign mid_w = sum[cbs_pkg::IDX_BITS:1];
  assign tbl_raddr_o = mid_w;

  // Flipping the sign bits of y and x turns the signed (y, x) order into a
  // plain unsigned compare of the packed word.
  assign entry_key = tbl_rdata_i ^ {SIGN_FLIP, SIGN_FLIP};
  assign key_eq    = (entry_key == key_q);
  assign key_gt    = (entry_key > key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    res_d   = res_q;
    case (state_q)
      cbs_pkg::ST_IDLE: begin
        if (accept) begin
          lo_d        = in_low_i;
          hi_d        = in_high_i;
          key_d       = {in_key_y_i, in_key_x_i} ^ {SIGN_FLIP, SIGN_FLIP};
          res_d.found = 1'b0;
          res_d.index = '0;
          if (in_action_i == cbs_pkg::ACT_SEARCH && bounds_ok) begin
            state_d = cbs_pkg::ST_PROBE;
          end else begin
            state_d = cbs_pkg::ST_RESULT;
          end
        end
      end
      cbs_pkg::ST_PROBE: begin
        if (lo_q > hi_q) begin
          state_d = cbs_pkg::ST_RESULT;
        end else begin
          mid_d   = mid_w;
          state_d = cbs_pkg::ST_COMPARE;
        end
      end
      cbs_pkg::ST_COMPARE: begin
        if (key_eq) begin
          res_d.found = 1'b1;
          res_d.index = mid_q;
          state_d     = cbs_pkg::ST_RESULT;
        end else begin
          if (key_gt) begin
            hi_d = $signed({2'b00, mid_q}) - cbs_pkg::BOUND_BITS'(1);
          end else begin
            lo_d = $signed({2'b00, mid_q}) + cbs_pkg::BOUND_BITS'(1);
          end
          state_d = cbs_pkg::ST_PROBE;
        end
      end
      cbs_pkg::ST_RESULT: begin
        if (res_ready_i) begin
          state_d = cbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbs_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = (state_q == cbs_pkg::ST_RESULT);
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_compare_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbs_pkg::ST_COMPARE |-> $past(state_q) == cbs_pkg::ST_PROBE)
    else $error("compare step without a preceding probe");

  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbs_pkg::ST_PROBE |->
      !lo_q[cbs_pkg::BOUND_BITS-1] && (hi_q >= -cbs_pkg::BOUND_BITS'(1)))
    else $error("search window left the table");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("pending result dropped or changed");
`endif

endmodule

// ===== tb/coordinate_search_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coordinate_search_checker
// Watches the load/search, result and entry-count channels of the coordinate
// search block. It keeps its own copy of the coordinate table and entry count,
// predicts one result per accepted item and compares each result transfer,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module coordinate_search_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [31:0]                  s_tdata_i,  // entry_index, key_x, key_y, low_bound,
                                                   // high_bound
  input  logic                         s_tuser_i,  // action
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [7:0]                   m_tdata_i,  // found_index, zero fill
  input  logic                         m_tuser_i,  // found
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [cbs_pkg::CNT_BITS-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  logic [cbs_pkg::ENTRY_BITS-1:0] coord_table [cbs_pkg::TABLE_DEPTH];
  logic [cbs_pkg::CNT_BITS-1:0]   entry_count;
  // Newest prediction at the front, oldest at the back.
  cbs_pkg::res_t                  pending_results [$];
  cbs_pkg::res_t                  want;
  int                             fails;

  // Binary search over the window, comparing y first and then x.
  function automatic cbs_pkg::res_t search_table(
      input logic signed [cbs_pkg::COORD_BITS-1:0] kx,
      input logic signed [cbs_pkg::COORD_BITS-1:0] ky,
      input logic signed [cbs_pkg::BOUND_BITS-1:0] lo_b,
      input logic signed [cbs_pkg::BOUND_BITS-1:0] hi_b);
    int                                    lo;
    int                                    hi;
    int                                    mid;
    int                                    limit;
    logic signed [cbs_pkg::COORD_BITS-1:0] ex;
    logic signed [cbs_pkg::COORD_BITS-1:0] ey;
    cbs_pkg::res_t                         r;
    r     = '0;
    lo    = lo_b;
    hi    = hi_b;
    limit = (entry_count > cbs_pkg::TABLE_DEPTH) ? cbs_pkg::TABLE_DEPTH : int'(entry_count);
    if (lo < 0 || lo >= limit || hi < 0 || hi >= limit) return r;
    while (lo <= hi) begin
      mid      = (lo + hi) / 2;
      {ey, ex} = coord_table[mid];
      if (ey == ky && ex == kx) begin
        r.found = 1'b1;
        r.index = cbs_pkg::IDX_BITS'(mid);
        return r;
      end
      if (ey > ky || (ey == ky && ex > kx)) hi = mid - 1;
      else lo = mid + 1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count = cbs_pkg::COUNT_RESET;
      pending_results.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) entry_count = cfg_data_i;

      // A result passes the search state register and the output register after its
      // item is taken, so results are checked before the item accepted at this same edge is predicted.
      if (m_tvalid_i && m_tready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, found %b index %0d",
                   $time, m_tuser_i, m_tdata_i);
          fails++;
        end else begin
          want = pending_results.pop_back();
          if (m_tuser_i !== want.found) begin
            $display("%0t ns: found expected %b, actual %b", $time, want.found, m_tuser_i);
            fails++;
          end
          if (m_tdata_i !== 8'(want.index)) begin
            $display("%0t ns: found_index expected %0d, actual %0d (tdata %h)",
                     $time, want.index, m_tdata_i[3:0], m_tdata_i);
            fails++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (cbs_pkg::action_e'(s_tuser_i) == cbs_pkg::ACT_LOAD) begin
          coord_table[s_tdata_i[3:0]] = {s_tdata_i[19:12], s_tdata_i[11:4]};
          pending_results.push_front('0);
        end else begin
          pending_results.push_front(search_table(s_tdata_i[11:4], s_tdata_i[19:12],
                                                  s_tdata_i[25:20], s_tdata_i[31:26]));
        end
      end

      pending_o    <= pending_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/tb_coordinate_binary_search.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coordinate_binary_search
// Drives loads and searches into the coordinate search block across several
// entry-count settings, with bursty input and a stalling result side, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_coordinate_binary_search;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 80;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [31:0]                  s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [cbs_pkg::CNT_BITS-1:0] cfg_data_i    = '0;

  int                             fail_count;
  int                             pending;
  int                             cycle_cnt   = 0;
  int                             burst_left  = 0;
  logic [7:0]                     hold_req    = '0;
  logic [cbs_pkg::ENTRY_BITS-1:0] loaded_coords [cbs_pkg::TABLE_DEPTH];
  logic [cbs_pkg::CNT_BITS-1:0]   fixed_counts [6] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2};

  coordinate_binary_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  coordinate_search_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random duty-cycle stall patterns that change from pattern to
  // pattern, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int         rx_period;
    int         rx_duty;
    int         rx_left;
    int         rx_phase;
    logic [7:0] hold_seen;
    rx_left   = 0;
    rx_period = 1;
    rx_duty   = 1;
    rx_phase  = 0;
    hold_seen = '0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (rx_left == 0) begin
        rx_period = $urandom_range(1, 8);
        rx_duty   = $urandom_range(1, rx_period);
        if ($urandom_range(0, 3) == 0) rx_duty = rx_period;
        rx_left   = $urandom_range(16, 96);
        rx_phase  = 0;
      end
      m_axis_tready <= (rx_phase < rx_duty);
      rx_phase = (rx_phase + 1) % rx_period;
      rx_left--;
    end
  end

  // One transfer on the input channel; the sender goes quiet between bursts.
  task automatic send_item(input cbs_pkg::action_e act,
                           input logic [cbs_pkg::IDX_BITS-1:0] slot,
                           input logic [cbs_pkg::COORD_BITS-1:0] kx,
                           input logic [cbs_pkg::COORD_BITS-1:0] ky,
                           input logic [cbs_pkg::BOUND_BITS-1:0] lo_b,
                           input logic [cbs_pkg::BOUND_BITS-1:0] hi_b);
    s_axis_tuser  <= act;
    s_axis_tdata  <= {hi_b, lo_b, ky, kx, slot};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_slot(input logic [cbs_pkg::IDX_BITS-1:0] slot,
                           input logic [cbs_pkg::ENTRY_BITS-1:0] coord);
    loaded_coords[slot] = coord;
    send_item(cbs_pkg::ACT_LOAD, slot, coord[7:0], coord[15:8],
              cbs_pkg::BOUND_BITS'($urandom()), cbs_pkg::BOUND_BITS'($urandom()));
  endtask

  task automatic search_key(input logic [cbs_pkg::ENTRY_BITS-1:0] coord,
                            input logic [cbs_pkg::BOUND_BITS-1:0] lo_b,
                            input logic [cbs_pkg::BOUND_BITS-1:0] hi_b);
    send_item(cbs_pkg::ACT_SEARCH, cbs_pkg::IDX_BITS'($urandom()), coord[7:0], coord[15:8],
              lo_b, hi_b);
  endtask

  // Loads slots 0..n-1 in (y, x) order. The sort key is y then x, each with
  // its sign bit flipped, so an unsigned running sum stays sorted.
  task automatic load_sorted_table(input int n, input int step_max, input bit pin_ends);
    int          key;
    logic [15:0] k;
    key = pin_ends ? 0 : $urandom_range(0, 65535 - n * step_max);
    for (int i = 0; i < n; i++) begin
      k = (pin_ends && i == n - 1) ? 16'hffff : 16'(key);
      load_slot(cbs_pkg::IDX_BITS'(i), k ^ 16'h8080);
      key = key + $urandom_range(0, step_max);
      if (key > 65535) key = 65535;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [cbs_pkg::CNT_BITS-1:0] value);
    wait_drained();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_step();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 3);
      1:       return 256;
      2:       return 1024;
      default: return 4000;
    endcase
  endfunction

  initial begin
    logic [cbs_pkg::CNT_BITS-1:0]   count_setting;
    logic [cbs_pkg::ENTRY_BITS-1:0] coord;
    int                             n_eff;
    int                             lo;
    int                             hi;
    int                             roll;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 40);

    // Directed part at the reset entry count: a full table with the extreme
    // coordinates at both ends, then hits, a miss, an empty window and
    // bounds outside the valid range.
    load_sorted_table(cbs_pkg::TABLE_DEPTH, 4000, 1'b1);
    search_key(loaded_coords[0], 6'd0, 6'd15);
    search_key(loaded_coords[15], 6'd0, 6'd15);
    search_key(loaded_coords[7], 6'd7, 6'd7);
    search_key(loaded_coords[5] + 16'd1, 6'd0, 6'd15);
    search_key(loaded_coords[5], 6'd9, 6'd3);
    search_key(loaded_coords[3], 6'b100000, 6'd15);
    search_key(loaded_coords[3], 6'd0, 6'b011111);
    search_key(loaded_coords[0], 6'd16, 6'd16);
    search_key(loaded_coords[0], 6'b111111, 6'b111111);

    for (int p = 0; p < PHASES; p++) begin
      count_setting = (p < 6) ? fixed_counts[p] : cbs_pkg::CNT_BITS'($urandom_range(0, 31));
      write_entry_count(count_setting);
      n_eff = (count_setting > cbs_pkg::TABLE_DEPTH) ? cbs_pkg::TABLE_DEPTH
                                                     : int'(count_setting);
      load_sorted_table((n_eff == 0) ? 1 : n_eff, pick_step(), 1'b0);

      for (int it = 0; it < PHASE_ITEMS; it++) begin
        // Hold the result side off for a while so the block backs up.
        if (it == 20) hold_req <= hold_req + 8'd1;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          load_sorted_table((n_eff == 0) ? 1 : n_eff, pick_step(), 1'b0);
        end else if (roll < 9) begin
          load_slot(cbs_pkg::IDX_BITS'($urandom()), cbs_pkg::ENTRY_BITS'($urandom()));
        end else if (roll < 20 || n_eff == 0) begin
          search_key(cbs_pkg::ENTRY_BITS'($urandom()), cbs_pkg::BOUND_BITS'($urandom()),
                     cbs_pkg::BOUND_BITS'($urandom()));
        end else begin
          lo = $urandom_range(0, n_eff - 1);
          hi = $urandom_range(lo, n_eff - 1);
          if ($urandom_range(0, 3) == 0) begin
            lo = 0;
            hi = n_eff - 1;
          end
          coord = loaded_coords[$urandom_range(lo, hi)];
          case ($urandom_range(0, 9))
            0:       coord[7:0] = coord[7:0] + 8'd1;
            1:       coord[7:0] = coord[7:0] - 8'd1;
            2:       coord[15:8] = 8'($urandom());
            default: ;
          endcase
          search_key(coord, cbs_pkg::BOUND_BITS'(lo), cbs_pkg::BOUND_BITS'(hi));
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
